/* hdl/assert_macros.svh */
// Assertion macros used by the glyph row blitter top level.
// Needs nothing else; included only by the top level, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/grbe_pkg.sv */
// Types, constants and helper functions for the glyph row blitter.
// Used by every module of the block; depends on nothing.
package grbe_pkg;

  localparam int MODE_COUNT  = 20;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // style flag bit positions
  localparam int FLAG_THICKEN = 0;
  localparam int FLAG_LIGHTEN = 1;
  localparam int FLAG_SKEW    = 2;

  localparam logic [4:0]  RESET_WRITE_MODE   = 5'd0;
  localparam logic [7:0]  RESET_FORE_COLOR   = 8'd1;
  localparam logic [7:0]  RESET_BACK_COLOR   = 8'd0;
  localparam logic [2:0]  RESET_STYLE_FLAGS  = 3'd0;
  localparam logic [4:0]  RESET_SMEAR_WIDTH  = 5'd0;
  localparam logic [5:0]  RESET_ROW_WIDTH    = 6'd8;
  localparam logic [15:0] RESET_LIGHTEN_MASK = 16'h5555;
  localparam logic [15:0] RESET_SKEW_MASK    = 16'h5555;

  typedef enum logic [3:0] {
    REG_WRITE_MODE   = 4'd0,
    REG_FORE_COLOR   = 4'd1,
    REG_BACK_COLOR   = 4'd2,
    REG_STYLE_FLAGS  = 4'd3,
    REG_SMEAR_WIDTH  = 4'd4,
    REG_ROW_WIDTH    = 4'd5,
    REG_LIGHTEN_MASK = 4'd6,
    REG_SKEW_MASK    = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [4:0]  write_mode;
    logic [7:0]  fore_color;
    logic [7:0]  back_color;
    logic [2:0]  style_flags;
    logic [4:0]  smear_width;
    logic [5:0]  row_width;
    logic [15:0] lighten_mask;
    logic [15:0] skew_mask;
  } cfg_t;

  // one classified row, ready for the pixel datapath
  typedef struct packed {
    logic        plane_ok;
    logic [3:0]  op;
    logic [5:0]  width;
    logic [4:0]  smear;
    logic        thicken;
    logic        lighten;
    logic [7:0]  lean;
    logic [15:0] screen;
    logic [7:0]  src_ofs;
    logic [63:0] src;
    logic [3:0]  dst_ofs;
    logic [63:0] dst;
  } row_job_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  typedef logic [3:0] rop_t;

  // columns: {fore bit, back bit}
  localparam rop_t ROP_TABLE [MODE_COUNT][4] = '{
    '{4'd0, 4'd0,  4'd3,  4'd3},
    '{4'd4, 4'd4,  4'd7,  4'd7},
    '{4'd6, 4'd6,  4'd6,  4'd6},
    '{4'd1, 4'd1,  4'd13, 4'd13},
    '{4'd0, 4'd15, 4'd0,  4'd15},
    '{4'd0, 4'd14, 4'd1,  4'd15},
    '{4'd0, 4'd13, 4'd2,  4'd15},
    '{4'd0, 4'd12, 4'd3,  4'd15},
    '{4'd0, 4'd11, 4'd4,  4'd15},
    '{4'd0, 4'd10, 4'd5,  4'd15},
    '{4'd0, 4'd9,  4'd6,  4'd15},
    '{4'd0, 4'd8,  4'd7,  4'd15},
    '{4'd0, 4'd7,  4'd8,  4'd15},
    '{4'd0, 4'd6,  4'd9,  4'd15},
    '{4'd0, 4'd5,  4'd10, 4'd15},
    '{4'd0, 4'd4,  4'd11, 4'd15},
    '{4'd0, 4'd3,  4'd12, 4'd15},
    '{4'd0, 4'd2,  4'd13, 4'd15},
    '{4'd0, 4'd1,  4'd14, 4'd15},
    '{4'd0, 4'd0,  4'd15, 4'd15}
  };

  function automatic rop_t op_lookup(input logic [4:0] mode, input logic fg, input logic bg);
    rop_t op;
    if (mode < 5'(MODE_COUNT)) begin
      op = ROP_TABLE[mode][{fg, bg}];
    end else begin
      op = ROP_TABLE[0][{fg, bg}];
    end
    return op;
  endfunction

  function automatic logic [15:0] rotl16(input logic [15:0] v, input logic [3:0] n);
    logic [31:0] tmp;
    tmp = {v, v} << n;
    return tmp[31:16];
  endfunction

endpackage

/* hdl/grbe_cfg.sv */
// Configuration register file of the glyph row blitter.
// Depends on grbe_pkg for the register map and reset values.
module grbe_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output grbe_pkg::cfg_t     cfg
);
  import grbe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.write_mode   <= RESET_WRITE_MODE;
      cfg.fore_color   <= RESET_FORE_COLOR;
      cfg.back_color   <= RESET_BACK_COLOR;
      cfg.style_flags  <= RESET_STYLE_FLAGS;
      cfg.smear_width  <= RESET_SMEAR_WIDTH;
      cfg.row_width    <= RESET_ROW_WIDTH;
      cfg.lighten_mask <= RESET_LIGHTEN_MASK;
      cfg.skew_mask    <= RESET_SKEW_MASK;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_WRITE_MODE: begin
          // out-of-range modes fall back to replace
          cfg.write_mode <= (cfg_data[4:0] >= 5'(MODE_COUNT)) ? RESET_WRITE_MODE
                                                               : cfg_data[4:0];
        end
        REG_FORE_COLOR:   cfg.fore_color   <= cfg_data[7:0];
        REG_BACK_COLOR:   cfg.back_color   <= cfg_data[7:0];
        REG_STYLE_FLAGS:  cfg.style_flags  <= cfg_data[2:0];
        REG_SMEAR_WIDTH:  cfg.smear_width  <= cfg_data[4:0];
        REG_ROW_WIDTH:    cfg.row_width    <= cfg_data[5:0];
        REG_LIGHTEN_MASK: cfg.lighten_mask <= cfg_data;
        REG_SKEW_MASK:    cfg.skew_mask    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* hdl/grbe_front.sv */
// Front end: classifies each accepted row and keeps one effect state for all planes.
// Depends on grbe_pkg for the job type, the raster-op table and rotl16.
module grbe_front #(
  parameter int MAX_ROW_WIDTH = 48,
  parameter int MAX_PLANES    = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  grbe_pkg::cfg_t       cfg,
  input  logic                 push,
  input  logic [2:0]           plane_index,
  input  logic                 first_row,
  input  logic [15:0]          source_bit_offset,
  input  logic [63:0]          source_window,
  input  logic [3:0]           dest_bit_offset,
  input  logic [63:0]          dest_window,
  output grbe_pkg::row_job_t   job
);
  import grbe_pkg::*;

  logic [15:0] lighten_now, lighten_now_next;
  logic [15:0] skew_now, skew_now_next;
  logic [7:0]  lean_shift, lean_shift_next;

  logic [15:0] light0, skew0;
  logic [7:0]  lean0;
  logic [5:0]  width;
  logic [16:0] words_sum;
  logic        plane_ok;

  always_comb begin
    plane_ok = {1'b0, plane_index} < 4'(MAX_PLANES);
    width    = (cfg.row_width > 6'(MAX_ROW_WIDTH)) ? 6'(MAX_ROW_WIDTH) : cfg.row_width;

    // reload at a plane's first row
    light0 = first_row ? cfg.lighten_mask : lighten_now;
    skew0  = first_row ? cfg.skew_mask : skew_now;
    lean0  = first_row ? 8'd0 : lean_shift;

    skew_now_next   = skew0;
    lean_shift_next = lean0;
    if (cfg.style_flags[FLAG_SKEW]) begin
      skew_now_next = rotl16(skew0, 4'd1);
      if (skew0[15] && (lean0 != 8'hFF)) begin
        lean_shift_next = lean0 + 8'd1;
      end
    end

    // advance the screen by the number of source words the row spans
    words_sum = {1'b0, source_bit_offset} + 17'(width) + 17'd15;
    lighten_now_next = light0;
    if (cfg.style_flags[FLAG_LIGHTEN]) begin
      lighten_now_next = rotl16(light0, words_sum[7:4]);
    end

    job.plane_ok = plane_ok;
    job.op       = op_lookup(cfg.write_mode, cfg.fore_color[plane_index],
                             cfg.back_color[plane_index]);
    job.width    = width;
    job.smear    = cfg.smear_width;
    job.thicken  = cfg.style_flags[FLAG_THICKEN];
    job.lighten  = cfg.style_flags[FLAG_LIGHTEN];
    job.lean     = lean_shift_next;
    job.screen   = light0;
    job.src_ofs  = source_bit_offset[7:0];
    job.src      = source_window;
    job.dst_ofs  = dest_bit_offset;
    job.dst      = dest_window;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lighten_now <= RESET_LIGHTEN_MASK;
      skew_now    <= RESET_SKEW_MASK;
      lean_shift  <= 8'd0;
    end else if (push && plane_ok) begin
      lighten_now <= lighten_now_next;
      skew_now    <= skew_now_next;
      lean_shift  <= lean_shift_next;
    end
  end

endmodule

/* hdl/grbe_queue.sv */
// Two-entry job queue between the front end and the pixel datapath.
// Depends on grbe_pkg for the job and status types.
module grbe_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  grbe_pkg::row_job_t   push_job,
  input  logic                 pop,
  output grbe_pkg::row_job_t   head_job,
  output grbe_pkg::q_status_t  status
);
  import grbe_pkg::*;

  row_job_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  always_comb begin
    head_job     = slots[rd_ptr];
    status.count = count;
    status.empty = (count == '0);
    status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

/* hdl/grbe_back.sv */
// Back end: two-stage pixel datapath (source row, then smear and raster op)
// with the output register. Depends on grbe_pkg for the job and status types.
module grbe_back #(
  parameter int MAX_ROW_WIDTH = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  grbe_pkg::row_job_t   head_job,
  input  grbe_pkg::q_status_t  q_status,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          dest_window_out
);
  import grbe_pkg::*;

  localparam int RW = MAX_ROW_WIDTH;

  logic advance;

  // stage 1 signals
  logic [63:0]   src_aligned;
  logic [RW-1:0] src_row, pix_in, wmask_in;
  logic [7:0]    abit;
  logic [3:0]    lidx;

  // stage 1 registers
  logic          s1_valid;
  logic [RW-1:0] pix, wmask;
  logic          plane_ok;
  logic [3:0]    op;
  logic [4:0]    smear;
  logic          thicken;
  logic [3:0]    dst_ofs;
  logic [63:0]   dst;

  // stage 2 signals
  logic [RW-1:0] thk;
  logic [63:0]   s_vec, m_vec, rop_vec, result;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !q_status.empty;

  always_comb begin
    // column c of the glyph sits at bit 63-c after alignment
    src_aligned = head_job.src << head_job.src_ofs[3:0];
    for (int col = 0; col < RW; col++) begin
      abit = head_job.src_ofs + 8'(col);
      // screen rotated by word index, then bit of the column within the word
      lidx = 4'd15 - abit[3:0] - abit[7:4];
      src_row[col] = src_aligned[63 - col]
                     && ((7'(col) + 7'(head_job.smear)) < 7'(head_job.width))
                     && (!head_job.lighten || head_job.screen[lidx]);
      wmask_in[col] = (7'(col) < 7'(head_job.width));
    end
    if (head_job.lean >= 8'(RW)) begin
      pix_in = '0;
    end else begin
      pix_in = (src_row << head_job.lean[5:0]) & wmask_in;
    end
  end

  always_comb begin
    thk = pix;
    if (thicken) begin
      for (int k = 1; k < 32; k++) begin
        if ((k < RW) && (5'(k) <= smear)) begin
          thk = thk | (pix << k);
        end
      end
    end
    thk = thk & wmask;

    s_vec = '0;
    m_vec = '0;
    for (int c = 0; c < RW; c++) begin
      s_vec[63 - c] = thk[c];
      m_vec[63 - c] = wmask[c];
    end
    s_vec = s_vec >> dst_ofs;
    m_vec = plane_ok ? (m_vec >> dst_ofs) : 64'd0;

    rop_vec = (~s_vec & ~dst & {64{op[3]}})
            | (~s_vec &  dst & {64{op[2]}})
            | ( s_vec & ~dst & {64{op[1]}})
            | ( s_vec &  dst & {64{op[0]}});
    result = (rop_vec & m_vec) | (dst & ~m_vec);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pix      <= pix_in;
      wmask    <= wmask_in;
      plane_ok <= head_job.plane_ok;
      op       <= head_job.op;
      smear    <= head_job.smear;
      thicken  <= head_job.thicken;
      dst_ofs  <= head_job.dst_ofs;
      dst      <= head_job.dst;
      dest_window_out <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= !q_status.empty;
      out_valid <= s1_valid;
    end
  end

endmodule

/* hdl/glyph_row_blit_with_effects.sv */
// Glyph row blitter: takes one item per clock while in_stall is low and
// returns one result item per input item, in order. The front end updates
// the skew, lean and lighten state as the item is taken, a two-entry queue
// holds classified rows, and the back end runs a two-stage pixel datapath
// into the output register. The queue sets the throughput: input stall
// rises only when both entries hold rows that the stalled output side has
// not drained. No clearing pass after reset. Depends on grbe_pkg and
// assert_macros.svh.
`include "assert_macros.svh"

module glyph_row_blit_with_effects #(
  parameter int MAX_ROW_WIDTH = 48,
  parameter int MAX_PLANES    = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  plane_index,
  input  logic        first_row,
  input  logic [15:0] source_bit_offset,
  input  logic [63:0] source_window,
  input  logic [3:0]  dest_bit_offset,
  input  logic [63:0] dest_window,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] dest_window_out
);
  import grbe_pkg::*;

  cfg_t      cfg;
  row_job_t  push_job, head_job;
  q_status_t q_status;
  logic      push, pop;

  assign in_stall = q_status.full;
  assign push     = in_valid && !in_stall;

  grbe_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  grbe_front #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .MAX_PLANES    (MAX_PLANES)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .push              (push),
    .plane_index       (plane_index),
    .first_row         (first_row),
    .source_bit_offset (source_bit_offset),
    .source_window     (source_window),
    .dest_bit_offset   (dest_bit_offset),
    .dest_window       (dest_window),
    .job               (push_job)
  );

  grbe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  grbe_back #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head_job        (head_job),
    .q_status        (q_status),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .dest_window_out (dest_window_out)
  );

  `ASSERT_NEXT(a_queue_fill, clk, rst, push && !pop, q_status.count == $past(q_status.count) + 2'd1, "queue count did not grow on push")
  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst, pop, !q_status.empty, "pop from empty queue")
  `ASSERT_IMPLIES(a_stall_full, clk, rst, in_stall, q_status.count == 2'(QUEUE_DEPTH), "input stalled with queue space left")

endmodule

/* verif/glyph_row_blit_with_effects_tb.sv */
// Self-checking testbench for the glyph row blitter: a scoreboard class predicts
// every result window from its own model of the skew, lighten and thicken effects.
// Depends on grbe_pkg and the glyph_row_blit_with_effects top level.
module glyph_row_blit_with_effects_tb;
  import grbe_pkg::*;

  localparam int MAX_ROW_WIDTH = 48;
  localparam int MAX_PLANES    = 8;
  localparam int STALL_LIMIT   = 3000;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_REPORTS   = 10;

  // write modes
  localparam int MODE_REPLACE         = 0;
  localparam int MODE_TRANSPARENT     = 1;
  localparam int MODE_XOR             = 2;
  localparam int MODE_REV_TRANSPARENT = 3;
  localparam int MODE_ROP_BASE        = 4;
  localparam int MODE_ROP_LAST        = 19;
  localparam int MODE_BEYOND_LAST     = 25;

  // raster ops used by the classic modes
  localparam logic [3:0] ROP_CLEAR      = 4'd0;
  localparam logic [3:0] ROP_AND        = 4'd1;
  localparam logic [3:0] ROP_SRC        = 4'd3;
  localparam logic [3:0] ROP_NOTS_AND_D = 4'd4;
  localparam logic [3:0] ROP_XOR        = 4'd6;
  localparam logic [3:0] ROP_OR         = 4'd7;
  localparam logic [3:0] ROP_NOTS_OR_D  = 4'd13;
  localparam logic [3:0] ROP_SET        = 4'd15;

  localparam logic [3:0] UNUSED_REG_INDEX = 4'd9;

  typedef struct {
    logic [2:0]  plane;
    logic        head;
    logic [15:0] sbo;
    logic [63:0] src;
    logic [3:0]  dbo;
    logic [63:0] dst;
  } glyph_row_t;

  class blit_scoreboard;
    logic [4:0]  mode_r;
    logic [7:0]  fore_r;
    logic [7:0]  back_r;
    logic [2:0]  style_r;
    logic [4:0]  smear_r;
    logic [5:0]  width_r;
    logic [15:0] lmask_r;
    logic [15:0] kmask_r;
    logic [15:0] lighten_now;
    logic [15:0] skew_now;
    int          lean;
    logic [63:0] expected_windows[$];
    int          mismatches;
    int          checked;

    function new();
      mode_r      = RESET_WRITE_MODE;
      fore_r      = RESET_FORE_COLOR;
      back_r      = RESET_BACK_COLOR;
      style_r     = RESET_STYLE_FLAGS;
      smear_r     = RESET_SMEAR_WIDTH;
      width_r     = RESET_ROW_WIDTH;
      lmask_r     = RESET_LIGHTEN_MASK;
      kmask_r     = RESET_SKEW_MASK;
      lighten_now = RESET_LIGHTEN_MASK;
      skew_now    = RESET_SKEW_MASK;
      lean        = 0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function logic [15:0] spin16(logic [15:0] v, int n);
      n = n & 15;
      if (n == 0) return v;
      return (v << n) | (v >> (16 - n));
    endfunction

    function void write_reg(logic [3:0] idx, logic [15:0] val);
      case (idx)
        REG_WRITE_MODE: begin
          mode_r = val[4:0];
          if (mode_r >= MODE_COUNT) mode_r = '0;
        end
        REG_FORE_COLOR:   fore_r  = val[7:0];
        REG_BACK_COLOR:   back_r  = val[7:0];
        REG_STYLE_FLAGS:  style_r = val[2:0];
        REG_SMEAR_WIDTH:  smear_r = val[4:0];
        REG_ROW_WIDTH:    width_r = val[5:0];
        REG_LIGHTEN_MASK: lmask_r = val;
        REG_SKEW_MASK:    kmask_r = val;
        default: ;
      endcase
    endfunction

    // sel is {fore bit, back bit} of the plane
    function logic [3:0] pick_op(logic [1:0] sel);
      int m;
      m = mode_r;
      case (m)
        MODE_REPLACE:         return sel[1] ? ROP_SRC : ROP_CLEAR;
        MODE_TRANSPARENT:     return sel[1] ? ROP_OR : ROP_NOTS_AND_D;
        MODE_XOR:             return ROP_XOR;
        MODE_REV_TRANSPARENT: return sel[1] ? ROP_NOTS_OR_D : ROP_AND;
        default: begin
          case (sel)
            2'b00:   return ROP_CLEAR;
            2'b01:   return 4'(MODE_ROP_LAST - m);
            2'b10:   return 4'(m - MODE_ROP_BASE);
            default: return ROP_SET;
          endcase
        end
      endcase
    endfunction

    function logic [63:0] predict_window(glyph_row_t r);
      int          width, span, col, c, i, rel, total, words;
      logic [31:0] abit;
      logic [3:0]  op;
      logic [15:0] m, old_skew;
      logic [63:0] win;
      bit          pix [MAX_ROW_WIDTH];
      bit          thk [MAX_ROW_WIDTH];
      bit          v;
      logic        d;
      win = r.dst;
      if (r.plane >= MAX_PLANES) return win;
      if (r.head) begin
        lighten_now = lmask_r;
        skew_now    = kmask_r;
        lean        = 0;
      end
      width = (width_r > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : int'(width_r);
      op = pick_op({fore_r[r.plane], back_r[r.plane]});
      if (style_r[FLAG_SKEW]) begin
        old_skew = skew_now;
        skew_now = spin16(skew_now, 1);
        if (old_skew[15] && lean < 255) lean++;
      end
      span = width - int'(smear_r);
      for (c = 0; c < MAX_ROW_WIDTH; c++) begin
        pix[c] = 1'b0;
        thk[c] = 1'b0;
      end
      for (c = 0; c < width; c++) begin
        col = c - lean;
        v = 1'b0;
        if (col >= 0 && col < span) begin
          rel  = int'(r.sbo[3:0]) + col;
          abit = 32'(r.sbo) + 32'(col);
          v = r.src[63 - rel];
          if (style_r[FLAG_LIGHTEN]) begin
            m = spin16(lighten_now, int'(abit[7:4]));
            v = v & m[15 - int'(abit[3:0])];
          end
        end
        pix[c] = v;
      end
      // smear lit pixels rightwards
      for (c = 0; c < width; c++) begin
        v = pix[c];
        if (style_r[FLAG_THICKEN] && !v) begin
          for (i = 1; i <= int'(smear_r) && i <= c; i++) begin
            if (pix[c - i]) begin
              v = 1'b1;
              break;
            end
          end
        end
        thk[c] = v;
      end
      for (c = 0; c < width; c++) begin
        d = win[63 - (int'(r.dbo) + c)];
        win[63 - (int'(r.dbo) + c)] = op[3 - int'({thk[c], d})];
      end
      if (style_r[FLAG_LIGHTEN]) begin
        total = int'(r.sbo) + width;
        words = (total == 0) ? 0 : ((total - 1) >> 4) + 1;
        lighten_now = spin16(lighten_now, words);
      end
      return win;
    endfunction

    function void note_row(glyph_row_t r);
      expected_windows.push_back(predict_window(r));
    endfunction

    function void check_result(logic [63:0] got);
      logic [63:0] want;
      if (expected_windows.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: dest_window_out %h arrived with no row pending", got);
        return;
      end
      want = expected_windows.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result %0d dest_window_out expected %h got %h", checked, want, got);
      end
    endfunction

    function int pending();
      return expected_windows.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [3:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  wire         in_stall;
  logic [2:0]  plane_index = '0;
  logic        first_row = 1'b0;
  logic [15:0] source_bit_offset = '0;
  logic [63:0] source_window = '0;
  logic [3:0]  dest_bit_offset = '0;
  logic [63:0] dest_window = '0;
  wire         out_valid;
  logic        out_stall = 1'b0;
  wire  [63:0] dest_window_out;

  blit_scoreboard sb;
  int rows_sent = 0;
  int settings_seen = 0;
  int results_seen = 0;
  int calm_rows = 0;
  int rx_hold = 0;
  int rx_calm = 0;
  int rx_pick = 0;
  int idle_cycles = 0;

  glyph_row_blit_with_effects DUT (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .plane_index       (plane_index),
    .first_row         (first_row),
    .source_bit_offset (source_bit_offset),
    .source_window     (source_window),
    .dest_bit_offset   (dest_bit_offset),
    .dest_window       (dest_window),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .dest_window_out   (dest_window_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: check accepted items and pick the stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result(dest_window_out);
        results_seen++;
        // hold off long enough that the block fills up and stalls its input
        if (results_seen == 500 || results_seen == 1300) rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else if (rx_calm > 0) begin
        out_stall <= 1'b0;
        rx_calm--;
      end else begin
        rx_pick = $urandom_range(0, 99);
        if (rx_pick < 70) begin
          out_stall <= 1'b0;
        end else if (rx_pick < 93) begin
          out_stall <= 1'b1;
          rx_hold = $urandom_range(0, 2);
        end else if (rx_pick < 98) begin
          out_stall <= 1'b1;
          rx_hold = $urandom_range(5, 30);
        end else begin
          out_stall <= 1'b0;
          rx_calm = $urandom_range(40, 160);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ERROR: no item moved for %0d cycles, %0d results pending",
                 idle_cycles, sb.pending());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic int next_gap();
    int r;
    if (calm_rows > 0) begin
      calm_rows--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    if (r < 99) return $urandom_range(20, 60);
    calm_rows = $urandom_range(30, 100);
    return 0;
  endfunction

  function automatic logic [63:0] random_source();
    // sparse windows leave room for thicken to show
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom} & {$urandom, $urandom};
    return {$urandom, $urandom};
  endfunction

  task automatic send_row(input glyph_row_t r);
    int gap;
    gap = next_gap();
    in_valid          <= 1'b1;
    plane_index       <= r.plane;
    first_row         <= r.head;
    source_bit_offset <= r.sbo;
    source_window     <= r.src;
    dest_bit_offset   <= r.dbo;
    dest_window       <= r.dst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_row(r);
    rows_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_fixed(input logic [2:0] plane, input logic head, input logic [15:0] sbo,
                            input logic [63:0] src, input logic [3:0] dbo,
                            input logic [63:0] dst);
    glyph_row_t r;
    r.plane = plane;
    r.head  = head;
    r.sbo   = sbo;
    r.src   = src;
    r.dbo   = dbo;
    r.dst   = dst;
    send_row(r);
  endtask

  // one glyph: a first row, then the rest of its rows in the same plane
  task automatic run_glyph(input logic [2:0] plane, input logic [15:0] sbo,
                           input logic [3:0] dbo, input int n_rows);
    int k;
    for (k = 0; k < n_rows; k++)
      send_fixed(plane, k == 0, sbo, random_source(), dbo, {$urandom, $urandom});
  endtask

  task automatic run_phase(input int n_items);
    int sent, n;
    logic [15:0] sbo;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        n = $urandom_range(3, 16);
        sbo = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 64)) : 16'($urandom);
        run_glyph(3'($urandom_range(0, 7)), sbo, 4'($urandom_range(0, 15)), n);
        sent += n;
      end else begin
        send_fixed(3'($urandom), 1'($urandom), 16'($urandom), {$urandom, $urandom},
                   4'($urandom), {$urandom, $urandom});
        sent++;
      end
    end
  endtask

  // stop sending and let every pending result come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [3:0] idx, input logic [15:0] val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic cfg_release();
    cfg_write_en <= 1'b0;
    settings_seen++;
    @(posedge clk);
  endtask

  task automatic setup_random();
    int r;
    r = $urandom_range(0, 99);
    cfg_write(REG_WRITE_MODE, (r < 85) ? 16'($urandom_range(0, 19)) : 16'($urandom_range(20, 31)));
    cfg_write(REG_FORE_COLOR, 16'($urandom_range(0, 255)));
    cfg_write(REG_BACK_COLOR, 16'($urandom_range(0, 255)));
    cfg_write(REG_STYLE_FLAGS, 16'($urandom_range(0, 7)));
    r = $urandom_range(0, 99);
    if (r < 50) cfg_write(REG_SMEAR_WIDTH, 16'($urandom_range(0, 4)));
    else if (r < 85) cfg_write(REG_SMEAR_WIDTH, 16'($urandom_range(5, 16)));
    else cfg_write(REG_SMEAR_WIDTH, 16'($urandom_range(17, 31)));
    r = $urandom_range(0, 99);
    if (r < 8) cfg_write(REG_ROW_WIDTH, 16'd0);
    else if (r < 25) cfg_write(REG_ROW_WIDTH, 16'($urandom_range(49, 63)));
    else cfg_write(REG_ROW_WIDTH, 16'($urandom_range(1, 48)));
    cfg_write(REG_LIGHTEN_MASK, 16'($urandom));
    cfg_write(REG_SKEW_MASK, 16'($urandom));
    cfg_write(4'($urandom_range(8, 15)), 16'($urandom));
    cfg_release();
  endtask

  task automatic setup_all(input logic [15:0] mode, input logic [15:0] fore,
                           input logic [15:0] back, input logic [15:0] style,
                           input logic [15:0] smear, input logic [15:0] width,
                           input logic [15:0] lmask, input logic [15:0] kmask);
    cfg_write(REG_WRITE_MODE, mode);
    cfg_write(REG_FORE_COLOR, fore);
    cfg_write(REG_BACK_COLOR, back);
    cfg_write(REG_STYLE_FLAGS, style);
    cfg_write(REG_SMEAR_WIDTH, smear);
    cfg_write(REG_ROW_WIDTH, width);
    cfg_write(REG_LIGHTEN_MASK, lmask);
    cfg_write(REG_SKEW_MASK, kmask);
    cfg_release();
  endtask

  task automatic run_directed();
    int p;
    // reset settings, field extremes
    send_fixed(3'd0, 1'b1, 16'h0000, 64'h0, 4'd0, 64'h0);
    send_fixed(3'd7, 1'b1, 16'hFFFF, '1, 4'd15, '1);
    send_fixed(3'd0, 1'b0, 16'h000F, random_source(), 4'd15, 64'h0);
    send_fixed(3'd1, 1'b0, 16'h8000, random_source(), 4'd8, {$urandom, $urandom});
    drain_results();
    // out-of-range mode falls back to replace, wide row saturates, all effects on,
    // and the unused index must leave everything alone
    cfg_write(REG_WRITE_MODE, 16'(MODE_BEYOND_LAST));
    cfg_write(REG_ROW_WIDTH, 16'd63);
    cfg_write(REG_STYLE_FLAGS, 16'd7);
    cfg_write(REG_SMEAR_WIDTH, 16'd3);
    cfg_write(REG_FORE_COLOR, 16'h00F0);
    cfg_write(REG_BACK_COLOR, 16'h00CC);
    cfg_write(REG_LIGHTEN_MASK, 16'hF00F);
    cfg_write(REG_SKEW_MASK, 16'hFFFF);
    cfg_write(UNUSED_REG_INDEX, 16'hFFFF);
    cfg_release();
    for (p = 0; p < MAX_PLANES; p++)
      send_fixed(3'(p), p < 2, 16'hFFF0, random_source(), 4'($urandom), {$urandom, $urandom});
    drain_results();
    // zero width: nothing drawn, lighten still advances
    cfg_write(REG_ROW_WIDTH, 16'd0);
    cfg_release();
    send_fixed(3'd2, 1'b0, 16'h0011, random_source(), 4'd3, {$urandom, $urandom});
    send_fixed(3'd3, 1'b0, 16'h0000, random_source(), 4'd0, {$urandom, $urandom});
    drain_results();
    // smear wider than the row leaves it blank
    cfg_write(REG_ROW_WIDTH, 16'd8);
    cfg_write(REG_SMEAR_WIDTH, 16'd31);
    cfg_release();
    send_fixed(3'd4, 1'b0, 16'h0023, '1, 4'd5, {$urandom, $urandom});
    send_fixed(3'd5, 1'b0, 16'h0007, '1, 4'd12, {$urandom, $urandom});
    drain_results();
    cfg_write(REG_SMEAR_WIDTH, 16'd1);
    cfg_write(REG_WRITE_MODE, 16'(MODE_ROP_LAST));
    cfg_release();
    send_fixed(3'd6, 1'b0, 16'h0101, random_source(), 4'd1, {$urandom, $urandom});
    send_fixed(3'd7, 1'b0, 16'h0202, random_source(), 4'd2, {$urandom, $urandom});
    drain_results();
    cfg_write(REG_WRITE_MODE, 16'(MODE_REV_TRANSPARENT));
    cfg_release();
    send_fixed(3'd4, 1'b0, 16'h0303, random_source(), 4'd9, {$urandom, $urandom});
    send_fixed(3'd5, 1'b0, 16'h0404, random_source(), 4'd14, {$urandom, $urandom});
  endtask

  initial begin
    int ph;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    // long glyph with every skew step leaning: lean saturates past the row
    drain_results();
    setup_all(16'(MODE_XOR), 16'h00FF, 16'h0000, 16'd6, 16'd2, 16'd48, 16'hFFFF, 16'hFFFF);
    run_glyph(3'($urandom), 16'($urandom), 4'($urandom), 300);
    for (ph = 0; ph < 10; ph++) begin
      drain_results();
      if (ph == 0) begin
        setup_all(16'(MODE_ROP_LAST), 16'h00FF, 16'h00FF, 16'd7, 16'd16, 16'd63,
                  16'hFFFF, 16'hFFFF);
      end else if (ph == 1) begin
        setup_all(16'(MODE_REPLACE), 16'h0000, 16'h0000, 16'd0, 16'd0, 16'd0,
                  16'h0000, 16'h0000);
      end else begin
        setup_random();
      end
      run_phase(155);
    end
    drain_results();
    repeat (8) @(posedge clk);
    $display("Summary: %0d rows over %0d register settings, %0d results checked",
             rows_sent, settings_seen, sb.checked);
    $display("Summary: %0d mismatches, %0d results left pending", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* glyph_row_blit_with_effects.f */
+incdir+hdl
hdl/grbe_pkg.sv
hdl/grbe_cfg.sv
hdl/grbe_front.sv
hdl/grbe_queue.sv
hdl/grbe_back.sv
hdl/glyph_row_blit_with_effects.sv
verif/glyph_row_blit_with_effects_tb.sv
